FILE: rtl/sae_pkg.sv
package sae_pkg;

   // Field widths of the request and response beats
   localparam int unsigned WordWidth    = 16;
   localparam int unsigned CodeWidth    = 13;
   localparam int unsigned ColourWidth  = 4;
   localparam int unsigned XWidth       = 10;
   localparam int unsigned YWidth       = 11;
   localparam int unsigned PosWidth     = 9;
   localparam int unsigned HeightWidth  = 2;
   localparam int unsigned TileIdxWidth = 3;

   // Control and status register port
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 4;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PRIORITY_MASK  = 2'd0,
      CSR_PRIORITY_VALUE = 2'd1,
      CSR_FLIP_SCREEN    = 2'd2
   } csr_index_type;

   // Position decode: pos = MirrorOrigin - signed 9-bit field
   localparam logic signed [YWidth-1:0] MirrorOrigin = 11'sd240;
   localparam logic signed [YWidth-1:0] RightEdge    = 11'sd256;
   localparam logic signed [YWidth-1:0] TilePitch    = 11'sd16;

endpackage

FILE: rtl/sae_req_if.sv
interface sae_req_if
   import sae_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] attr_word_y;
   logic [WordWidth-1:0] code_word;
   logic [WordWidth-1:0] attr_word_x;
   logic                 frame_odd;

   modport source (
      output valid, attr_word_y, code_word, attr_word_x, frame_odd,
      input  ready
   );

   modport sink (
      input  valid, attr_word_y, code_word, attr_word_x, frame_odd,
      output ready
   );
endinterface

FILE: rtl/sae_rsp_if.sv
interface sae_rsp_if
   import sae_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CodeWidth-1:0]     tile_code;
   logic [ColourWidth-1:0]   palette_select;
   logic                     mirror_x;
   logic                     mirror_y;
   logic signed [XWidth-1:0] screen_x;
   logic signed [YWidth-1:0] screen_y;
   logic                     last_tile;

   modport source (
      output valid, tile_code, palette_select, mirror_x, mirror_y,
             screen_x, screen_y, last_tile,
      input  ready
   );

   modport sink (
      input  valid, tile_code, palette_select, mirror_x, mirror_y,
             screen_x, screen_y, last_tile,
      output ready
   );
endinterface

FILE: rtl/sprite_attribute_expander.sv
// Sprite attribute expander.
// req_ch takes one beat per sprite: the Y/attribute word, the code word, the
// X/colour word and the frame parity bit. rsp_ch gives one beat per tile of
// that sprite (1, 2, 4 or 8 tiles), last_tile marking the final one; a
// disabled, masked or off-screen sprite, or a flashing one in an odd frame, gives no beat.
// The csr_ port writes priority mask, priority value and screen flip; write
// it only while no sprite is in flight.
// Sequence: a sprite is taken in the idle state, then three setup steps on
// the shared adder (X decode and skip test, Y decode, first row), then one
// tile per cycle while rsp_ch does not stall. A skipped sprite returns to idle
// after the X decode step. The single 11-bit adder, used once per cycle,
// serves all of these steps.
// req_ch.ready is high only in the idle state. The last tile sits in the
// response register while the next sprite is taken, so a stalled receiver
// holds the block only once it has a tile that cannot be loaded.
// A stalled rsp_ch holds its beat unchanged and stops the tile sequence.
// reset (synchronous) clears the configuration registers to zero, drops
// rsp_ch.valid and returns the sequencer to idle; no clearing pass is needed.
module sprite_attribute_expander
   import sae_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   sae_req_if.sink                  req_ch,
   sae_rsp_if.source                rsp_ch,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC_X,
      ST_CALC_Y,
      ST_FIRST_ROW,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [ColourWidth-1:0] priority_mask_ff;
   logic [ColourWidth-1:0] priority_value_ff;
   logic                   flip_screen_ff;

   // Captured sprite entry
   logic                   enable_ff;
   logic                   flip_x_ff;
   logic                   flip_y_ff;
   logic [HeightWidth-1:0] height_ff;
   logic [PosWidth-1:0]    pos_y_ff;
   logic [PosWidth-1:0]    pos_x_ff;
   logic [CodeWidth-1:0]   code_ff;
   logic [ColourWidth-1:0] colour_ff;
   logic                   flash_ff;
   logic                   odd_ff;

   // Working registers
   logic [TileIdxWidth-1:0]  last_idx_ff;  // tiles in sprite minus one
   logic [TileIdxWidth-1:0]  tile_idx_ff;  // counts down to zero
   logic signed [XWidth-1:0] x_ff;
   logic signed [YWidth-1:0] y_ff;

   // Response register
   logic                     rsp_valid_ff;
   logic [CodeWidth-1:0]     rsp_code_ff;
   logic [ColourWidth-1:0]   rsp_colour_ff;
   logic                     rsp_mirror_x_ff;
   logic                     rsp_mirror_y_ff;
   logic signed [XWidth-1:0] rsp_x_ff;
   logic signed [YWidth-1:0] rsp_y_ff;
   logic                     rsp_last_ff;

   // Shared adder
   logic signed [YWidth-1:0] add_a;
   logic signed [YWidth-1:0] add_b;
   logic                     add_sub;
   logic signed [YWidth-1:0] add_sum;

   logic signed [YWidth-1:0] pos_x_ext;
   logic signed [YWidth-1:0] pos_y_ext;
   logic [TileIdxWidth-1:0]  height_mask;
   logic [TileIdxWidth-1:0]  code_offset;
   logic [CodeWidth-1:0]     tile_code;
   logic                     skip;
   logic                     rsp_load;

   assign pos_x_ext = {{(YWidth-PosWidth){pos_x_ff[PosWidth-1]}}, pos_x_ff};
   assign pos_y_ext = {{(YWidth-PosWidth){pos_y_ff[PosWidth-1]}}, pos_y_ff};

   always_comb begin
      case (height_ff)
         2'd0:    height_mask = 3'd0;
         2'd1:    height_mask = 3'd1;
         2'd2:    height_mask = 3'd3;
         default: height_mask = 3'd7;
      endcase
   end

   // Operand selection for the one adder, by sequencer step
   always_comb begin
      add_a   = MirrorOrigin;
      add_b   = pos_x_ext;
      add_sub = 1'b1;
      case (state_ff)
         ST_CALC_X: begin
            add_b = pos_x_ext;
         end
         ST_CALC_Y: begin
            add_b = pos_y_ext;
         end
         ST_FIRST_ROW: begin
            // rows run upward unless the screen is flipped
            add_a   = y_ff;
            add_b   = signed'({{(YWidth-TileIdxWidth-4){1'b0}}, last_idx_ff, 4'd0});
            add_sub = ~flip_screen_ff;
         end
         ST_EMIT: begin
            // step back towards the sprite origin row
            add_a   = y_ff;
            add_b   = TilePitch;
            add_sub = flip_screen_ff;
         end
         default: begin
            add_a   = MirrorOrigin;
            add_b   = pos_x_ext;
            add_sub = 1'b1;
         end
      endcase
   end

   assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

   assign skip = !enable_ff
              || ((colour_ff & priority_mask_ff) != priority_value_ff)
              || (flash_ff && odd_ff)
              || (add_sum > RightEdge);

   // The low code bits are cleared to align the block to the height, so the offset ORs in
   assign code_offset = flip_y_ff ? tile_idx_ff : (last_idx_ff ^ tile_idx_ff);
   assign tile_code   = (code_ff & ~{{(CodeWidth-TileIdxWidth){1'b0}}, last_idx_ff})
                      | {{(CodeWidth-TileIdxWidth){1'b0}}, code_offset};

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         priority_mask_ff  <= '0;
         priority_value_ff <= '0;
         flip_screen_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRIORITY_MASK:  priority_mask_ff  <= csr_wdata;
            CSR_PRIORITY_VALUE: priority_value_ff <= csr_wdata;
            CSR_FLIP_SCREEN:    flip_screen_ff    <= csr_wdata[0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Entry capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         enable_ff <= req_ch.attr_word_y[15];
         flip_y_ff <= req_ch.attr_word_y[14];
         flip_x_ff <= req_ch.attr_word_y[13];
         height_ff <= req_ch.attr_word_y[12:11];
         pos_y_ff  <= req_ch.attr_word_y[PosWidth-1:0];
         code_ff   <= req_ch.code_word[CodeWidth-1:0];
         colour_ff <= req_ch.attr_word_x[15:12];
         flash_ff  <= req_ch.attr_word_x[11];
         pos_x_ff  <= req_ch.attr_word_x[PosWidth-1:0];
         odd_ff    <= req_ch.frame_odd;
      end
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  state_ff <= ST_CALC_X;
               end
            end
            ST_CALC_X: begin
               // hold the decoded column, mirrored back under screen flip
               x_ff        <= flip_screen_ff ? pos_x_ext[XWidth-1:0] : add_sum[XWidth-1:0];
               last_idx_ff <= height_mask;
               tile_idx_ff <= height_mask;
               state_ff    <= skip ? ST_IDLE : ST_CALC_Y;
            end
            ST_CALC_Y: begin
               y_ff     <= flip_screen_ff ? pos_y_ext : add_sum;
               state_ff <= ST_FIRST_ROW;
            end
            ST_FIRST_ROW: begin
               y_ff     <= add_sum;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_code_ff     <= tile_code;
                  rsp_colour_ff   <= colour_ff;
                  rsp_mirror_x_ff <= flip_x_ff ^ flip_screen_ff;
                  rsp_mirror_y_ff <= flip_y_ff ^ flip_screen_ff;
                  rsp_x_ff        <= x_ff;
                  rsp_y_ff        <= y_ff;
                  rsp_last_ff     <= (tile_idx_ff == '0);
                  y_ff            <= add_sum;
                  tile_idx_ff     <= tile_idx_ff - 1'b1;
                  if (tile_idx_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tile_code      = rsp_code_ff;
   assign rsp_ch.palette_select = rsp_colour_ff;
   assign rsp_ch.mirror_x       = rsp_mirror_x_ff;
   assign rsp_ch.mirror_y       = rsp_mirror_y_ff;
   assign rsp_ch.screen_x       = rsp_x_ff;
   assign rsp_ch.screen_y       = rsp_y_ff;
   assign rsp_ch.last_tile      = rsp_last_ff;

`ifndef SYNTHESIS
   // The final tile of a sprite returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (tile_idx_ff == '0)) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last tile");

   // A beat that is not the last leaves more tiles to emit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_tile) |-> (state_ff == ST_EMIT))
      else $error("non-final tile delivered with no tiles left");

   // Each emitted tile steps the tile counter down by one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (tile_idx_ff != '0)) |=> (tile_idx_ff == $past(tile_idx_ff) - 1'b1))
      else $error("tile counter did not step down");

   // No new sprite is taken while tiles remain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !(req_ch.valid && req_ch.ready))
      else $error("sprite accepted during tile emission");
`endif

endmodule
